/* sv/kcu_pkg.sv */
package kcu_pkg;

  localparam int LED_COUNT_DEF = 8;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // event opcodes
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CMD     = 2'd2;

  // command groups, value[7:5]
  localparam logic [2:0] CMD_RPT0   = 3'd0;
  localparam logic [2:0] CMD_RPT1   = 3'd1;
  localparam logic [2:0] CMD_LED    = 3'd2;
  localparam logic [2:0] CMD_LEDRD  = 3'd3;
  localparam logic [2:0] CMD_SWRD   = 3'd4;
  localparam logic [2:0] CMD_REPEAT = 3'd5;
  localparam logic [2:0] CMD_ENABLE = 3'd6;
  localparam logic [2:0] CMD_RESET  = 3'd7;

  localparam logic [7:0] KEY_ENTER = 8'h0d;
  localparam logic [7:0] KEY_SHIFT = 8'h10;
  localparam logic [7:0] KEY_CTRL  = 8'h11;
  localparam logic [7:0] KEY_GRAPH = 8'h12;
  localparam logic [7:0] KEY_F1    = 8'h70;
  localparam logic [7:0] KEY_F4    = 8'h73;
  localparam logic [7:0] SH_ENTER  = 8'h83;
  localparam logic [7:0] SH_F1     = 8'h84;

  localparam logic [7:0] BRK_SHIFT = 8'h86;
  localparam logic [7:0] BRK_CTRL  = 8'h8a;
  localparam logic [7:0] BRK_GRAPH = 8'h8c;
  localparam logic [7:0] LED_BASE  = 8'hc0;
  localparam logic [7:0] SW_BASE   = 8'h80;
  localparam logic [7:0] DIAG_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] value;
    logic       shift_held;
    logic       ctrl_held;
    logic       graph_held;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       clear_before;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    DK_SINGLE,
    DK_LED,
    DK_SW
  } desc_kind_t;

  // work descriptor between front and back
  typedef struct packed {
    desc_kind_t kind;
    logic [7:0] data;
    logic       clr;
  } desc_t;

  function automatic logic [7:0] kcu_rom(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h08: r = 8'h6d; 8'h09: r = 8'h77; 8'h0d: r = 8'h4e;
      8'h10: r = 8'h87; 8'h11: r = 8'h8b; 8'h12: r = 8'h8d; 8'h14: r = 8'h31;
      8'h1b: r = 8'h75;
      8'h20: r = 8'h32; 8'h21: r = 8'h0c; 8'h22: r = 8'h0b; 8'h23: r = 8'h6f;
      8'h24: r = 8'h6e; 8'h25: r = 8'h3d; 8'h26: r = 8'h3c; 8'h27: r = 8'h3e;
      8'h28: r = 8'h3f; 8'h2d: r = 8'h5e; 8'h2e: r = 8'h5f;
      8'h30: r = 8'h69; 8'h31: r = 8'h76; 8'h32: r = 8'h61; 8'h33: r = 8'h62;
      8'h34: r = 8'h63; 8'h35: r = 8'h64; 8'h36: r = 8'h65; 8'h37: r = 8'h66;
      8'h38: r = 8'h67; 8'h39: r = 8'h68;
      8'h41: r = 8'h43; 8'h42: r = 8'h37; 8'h43: r = 8'h35; 8'h44: r = 8'h45;
      8'h45: r = 8'h53; 8'h46: r = 8'h46; 8'h47: r = 8'h47; 8'h48: r = 8'h48;
      8'h49: r = 8'h58; 8'h4a: r = 8'h49; 8'h4b: r = 8'h4a; 8'h4c: r = 8'h4b;
      8'h4d: r = 8'h39; 8'h4e: r = 8'h38; 8'h4f: r = 8'h59;
      8'h50: r = 8'h5a; 8'h51: r = 8'h51; 8'h52: r = 8'h54; 8'h53: r = 8'h44;
      8'h54: r = 8'h55; 8'h55: r = 8'h57; 8'h56: r = 8'h36; 8'h57: r = 8'h52;
      8'h58: r = 8'h34; 8'h59: r = 8'h56; 8'h5a: r = 8'h33;
      8'h60: r = 8'h17; 8'h61: r = 8'h27; 8'h62: r = 8'h26; 8'h63: r = 8'h25;
      8'h64: r = 8'h1b; 8'h65: r = 8'h1a; 8'h66: r = 8'h19; 8'h67: r = 8'h2b;
      8'h68: r = 8'h2a; 8'h69: r = 8'h29; 8'h6a: r = 8'h2d; 8'h6b: r = 8'h18;
      8'h6c: r = 8'h2f; 8'h6d: r = 8'h28; 8'h6e: r = 8'h16; 8'h6f: r = 8'h2e;
      8'h70: r = 8'h73; 8'h71: r = 8'h72; 8'h72: r = 8'h71; 8'h73: r = 8'h01;
      8'h74: r = 8'h02; 8'h75: r = 8'h03; 8'h76: r = 8'h04; 8'h77: r = 8'h05;
      8'h78: r = 8'h06; 8'h79: r = 8'h07; 8'h7a: r = 8'h09; 8'h7b: r = 8'h0a;
      8'h83: r = 8'h11; 8'h84: r = 8'h0f; 8'h85: r = 8'h1f; 8'h86: r = 8'h1e;
      8'h87: r = 8'h1d;
      8'hba: r = 8'h4d; 8'hbb: r = 8'h4c; 8'hbc: r = 8'h3a; 8'hbd: r = 8'h6a;
      8'hbe: r = 8'h3b; 8'hbf: r = 8'h4f;
      8'hc0: r = 8'h5b;
      8'hdb: r = 8'h5c; 8'hdc: r = 8'h6c; 8'hdd: r = 8'h5d; 8'hde: r = 8'h6b;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* sv/kcu_front.sv */
module kcu_front #(
  parameter int LED_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  kcu_pkg::in_item_t item,
  output logic             q_push,
  output kcu_pkg::desc_t   q_data
);
  import kcu_pkg::*;

  logic [LED_COUNT-1:0] led_bits, led_bits_next;
  logic                 keys_enabled, keys_enabled_next;
  logic                 repeat_on, repeat_on_next;
  logic [7:0]           code;
  logic [7:0]           rom_code;

  // shift remap ahead of the rom
  always_comb begin
    code = item.value;
    if (item.shift_held) begin
      if (item.value == KEY_ENTER) begin
        code = SH_ENTER;
      end else if (item.value >= KEY_F1 && item.value <= KEY_F4) begin
        code = SH_F1 + (item.value - KEY_F1);
      end
    end
    rom_code = kcu_rom(code);
  end

  always_comb begin
    led_bits_next     = led_bits;
    keys_enabled_next = keys_enabled;
    repeat_on_next    = repeat_on;
    q_push            = 1'b0;
    q_data.kind       = DK_SINGLE;
    q_data.data       = rom_code;
    q_data.clr        = 1'b0;
    if (accept) begin
      unique case (item.opcode)
        OP_PRESS: begin
          q_push = keys_enabled && (rom_code != 8'h00);
        end
        OP_RELEASE: begin
          if (keys_enabled) begin
            case (item.value)
              KEY_SHIFT: begin q_push = 1'b1; q_data.data = BRK_SHIFT; end
              KEY_CTRL:  begin q_push = 1'b1; q_data.data = BRK_CTRL;  end
              KEY_GRAPH: begin q_push = 1'b1; q_data.data = BRK_GRAPH; end
              default: ;
            endcase
          end
        end
        OP_CMD: begin
          unique case (item.value[7:5])
            CMD_REPEAT: repeat_on_next = item.value[0];
            CMD_LED: begin
              for (int j = 0; j < LED_COUNT; j++) begin
                if (item.value[3:1] == 3'(j)) led_bits_next[j] = item.value[0];
              end
            end
            CMD_LEDRD: begin
              q_push      = 1'b1;
              q_data.kind = DK_LED;
              q_data.data = 8'(led_bits);
            end
            CMD_SWRD: begin
              q_push      = 1'b1;
              q_data.kind = DK_SW;
              q_data.data = {5'd0, item.shift_held, item.ctrl_held, item.graph_held};
            end
            CMD_ENABLE: keys_enabled_next = item.value[0];
            CMD_RESET: begin
              led_bits_next     = '0;
              keys_enabled_next = 1'b1;
              repeat_on_next    = 1'b1;
              q_push            = !item.value[0];
              q_data.data       = DIAG_BYTE;
              q_data.clr        = 1'b1;
            end
            CMD_RPT0, CMD_RPT1: ;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits     <= '0;
      keys_enabled <= 1'b1;
      repeat_on    <= 1'b1;
    end else begin
      led_bits     <= led_bits_next;
      keys_enabled <= keys_enabled_next;
      repeat_on    <= repeat_on_next;
    end
  end

endmodule

/* sv/kcu_queue.sv */
module kcu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kcu_pkg::desc_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output kcu_pkg::desc_t head
);
  import kcu_pkg::*;

  desc_t              entries [QDEPTH];
  logic [QPTR_W-1:0]  wptr, rptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

/* sv/kcu_back.sv */
module kcu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  kcu_pkg::desc_t    q_head,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output kcu_pkg::out_item_t result
);
  import kcu_pkg::*;

  logic [2:0] cnt;
  logic       out_valid;
  logic       load;
  out_item_t  nxt;
  logic       sw_bit;

  // switch burst carries shift, ctrl, graph in bytes three, five and six
  always_comb begin
    case (cnt)
      3'd3:    sw_bit = q_head.data[2];
      3'd5:    sw_bit = q_head.data[1];
      3'd6:    sw_bit = q_head.data[0];
      default: sw_bit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (q_head.kind)
      DK_LED: begin
        nxt.out_byte     = LED_BASE | {4'd0, cnt, q_head.data[cnt]};
        nxt.clear_before = (cnt == 3'd0);
        nxt.last         = (cnt == 3'd7);
      end
      DK_SW: begin
        nxt.out_byte     = SW_BASE | {4'd0, cnt, sw_bit};
        nxt.clear_before = (cnt == 3'd0);
        nxt.last         = (cnt == 3'd7);
      end
      default: begin
        nxt.out_byte     = q_head.data;
        nxt.clear_before = q_head.clr;
        nxt.last         = 1'b1;
      end
    endcase
  end

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && nxt.last;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= nxt.last ? 3'd0 : cnt + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/keyboard_controller_command_unit_core.sv */
// an accepted event's result reaches the result ports through the descriptor queue and then the output register
// throughput: one event per cycle while the queue has room; single-byte results drain one per cycle
// while pop is held, and a status-read burst occupies the back end for eight bytes, one per pop
// a four-entry descriptor queue lets events keep arriving during a burst
// reset (rst, synchronous): leds off, keyboard and repeat enabled, queue and output register empty
module keyboard_controller_command_unit_core #(
  parameter int LED_COUNT = kcu_pkg::LED_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  kcu_pkg::in_item_t  item,
  input  logic               pop,
  output logic               empty,
  output kcu_pkg::out_item_t result
);
  import kcu_pkg::*;

  // front side: decode, state update, descriptor out
  logic  accept;
  logic  f_push;
  desc_t f_data;

  // queue to back side
  logic  q_empty;
  logic  q_pop;
  desc_t q_head;

  // a transaction is taken whenever the descriptor queue has room
  assign accept = push && !full;

  kcu_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .q_push (f_push),
    .q_data (f_data)
  );

  // short queue so event intake goes on during a back-end burst until it is full
  kcu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_data),
    .pop       (q_pop),
    .full      (full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back side: expands each descriptor into its bytes into the output register
  kcu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

/* tb/sv/keyboard_controller_command_unit_core_tb.sv */
module keyboard_controller_command_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcu_pkg::*;

  localparam int LEDS = LED_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int EVENT_TARGET = 430;
  // opcode value the block has no use for
  localparam logic [1:0] OP_SPARE = 2'd3;

  // host key code to device key code, zero means the key sends nothing
  localparam logic [7:0] KEYMAP [256] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h6d, 8'h77, 8'h00, 8'h00, 8'h00, 8'h4e, 8'h00, 8'h00,
    8'h87, 8'h8b, 8'h8d, 8'h00, 8'h31, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h32, 8'h0c, 8'h0b, 8'h6f, 8'h6e, 8'h3d, 8'h3c, 8'h3e,
    8'h3f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5e, 8'h5f, 8'h00,
    8'h69, 8'h76, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h67, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h43, 8'h37, 8'h35, 8'h45, 8'h53, 8'h46, 8'h47,
    8'h48, 8'h58, 8'h49, 8'h4a, 8'h4b, 8'h39, 8'h38, 8'h59,
    8'h5a, 8'h51, 8'h54, 8'h44, 8'h55, 8'h57, 8'h36, 8'h52,
    8'h34, 8'h56, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h17, 8'h27, 8'h26, 8'h25, 8'h1b, 8'h1a, 8'h19, 8'h2b,
    8'h2a, 8'h29, 8'h2d, 8'h18, 8'h2f, 8'h28, 8'h16, 8'h2e,
    8'h73, 8'h72, 8'h71, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
    8'h06, 8'h07, 8'h09, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h11, 8'h0f, 8'h1f, 8'h1e, 8'h1d,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h4d, 8'h4c, 8'h3a, 8'h6a, 8'h3b, 8'h4f,
    8'h5b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h6c, 8'h5d, 8'h6b, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // mirror of the keyboard state plus the bytes still owed to the receiver
  class kbd_reply_board;
    out_item_t  bytes_owed[$];
    logic [7:0] led_state;
    bit         keys_on;
    bit         auto_repeat;
    int         mismatches;
    int         n_press, n_release, n_cmd, n_spare, n_status, n_checked;

    function new();
      restore_defaults();
      mismatches = 0;
      n_press = 0; n_release = 0; n_cmd = 0;
      n_spare = 0; n_status = 0; n_checked = 0;
    endfunction

    function void restore_defaults();
      led_state = '0;
      keys_on = 1'b1;
      auto_repeat = 1'b1;
    endfunction

    function void owe(logic [7:0] b, logic clr, logic fin);
      out_item_t r;
      r.out_byte = b;
      r.clear_before = clr;
      r.last = fin;
      bytes_owed.push_back(r);
    endfunction

    // predict what one accepted event sends
    function void note_event(in_item_t ev);
      logic [7:0] key;
      logic [7:0] b;
      logic [2:0] idx;
      case (ev.opcode)
        OP_PRESS: begin
          n_press++;
          if (keys_on) begin
            key = ev.value;
            // shift turns enter and f1..f4 into their shifted codes
            if (ev.shift_held) begin
              if (key == KEY_ENTER) key = SH_ENTER;
              else if (key >= KEY_F1 && key <= KEY_F4) key = SH_F1 + (key - KEY_F1);
            end
            if (KEYMAP[key] != 8'h00) owe(KEYMAP[key], 1'b0, 1'b1);
          end
        end
        OP_RELEASE: begin
          n_release++;
          if (keys_on) begin
            case (ev.value)
              KEY_SHIFT: owe(BRK_SHIFT, 1'b0, 1'b1);
              KEY_CTRL:  owe(BRK_CTRL, 1'b0, 1'b1);
              KEY_GRAPH: owe(BRK_GRAPH, 1'b0, 1'b1);
              default: ;
            endcase
          end
        end
        OP_CMD: begin
          n_cmd++;
          case (ev.value[7:5])
            CMD_REPEAT: auto_repeat = ev.value[0];
            CMD_LED: begin
              idx = ev.value[3:1];
              if (int'(idx) < LEDS) led_state[idx] = ev.value[0];
            end
            CMD_LEDRD: begin
              n_status++;
              for (int k = 0; k < 8; k++) begin
                b = LED_BASE | 8'(k << 1);
                if (k < LEDS) b[0] = led_state[k];
                owe(b, k == 0, k == 7);
              end
            end
            CMD_SWRD: begin
              n_status++;
              for (int k = 0; k < 8; k++) begin
                b = SW_BASE | 8'(k << 1);
                if (k == 3) b[0] = ev.shift_held;
                if (k == 5) b[0] = ev.ctrl_held;
                if (k == 6) b[0] = ev.graph_held;
                owe(b, k == 0, k == 7);
              end
            end
            CMD_ENABLE: keys_on = ev.value[0];
            CMD_RESET: begin
              restore_defaults();
              // diagnostic reply only when bit 0 is clear
              if (!ev.value[0]) owe(DIAG_BYTE, 1'b1, 1'b1);
            end
            default: ;
          endcase
        end
        default: n_spare++;
      endcase
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      n_checked++;
      if (bytes_owed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte %h clr %b last %b", $time,
                 got.out_byte, got.clear_before, got.last);
        return;
      end
      want = bytes_owed.pop_front();
      if (got.out_byte !== want.out_byte || got.clear_before !== want.clear_before ||
          got.last !== want.last) begin
        mismatches++;
        $display("%0t: mismatch expected byte %h clr %b last %b, got byte %h clr %b last %b",
                 $time, want.out_byte, want.clear_before, want.last,
                 got.out_byte, got.clear_before, got.last);
      end
    endfunction

    function int outstanding();
      return bytes_owed.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  kbd_reply_board sb = new();

  int cycles = 0;
  int burst_left = 0;
  int counted = 0;

  always #5ns clk = ~clk;

  keyboard_controller_command_unit_core #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .pop   (pop),
    .empty (empty),
    .result(result)
  );

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still owed", $time, sb.outstanding());
      $display("[keyboard_controller_command_unit_core] ERROR");
      $finish;
    end
  end

  // receiver side: check each popped byte, then pick pop for the next edge
  // stall modes: always ready, coin flip, long stalls with short ready windows
  int  pace_mode = 0;
  int  pace_left = 0;
  int  hold = 0;
  bit  stalled = 1'b0;

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_reply(result);
    if (pace_left == 0) begin
      pace_mode = $urandom_range(0, 2);
      pace_left = $urandom_range(20, 120);
    end
    pace_left--;
    case (pace_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      default: begin
        if (hold == 0) begin
          stalled = !stalled;
          hold = stalled ? $urandom_range(1, 15) : $urandom_range(1, 4);
        end
        hold--;
        pop <= !stalled;
      end
    endcase
  end

  // one transaction on the event side; push stays high inside a burst
  task automatic send_event(logic [1:0] op, logic [7:0] v, logic sh, logic ct, logic gr);
    in_item_t ev;
    ev.opcode = op;
    ev.value = v;
    ev.shift_held = sh;
    ev.ctrl_held = ct;
    ev.graph_held = gr;
    counted++;
    push <= 1'b1;
    item <= ev;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_event(ev);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_random_event();
    int         pick;
    logic [2:0] grp;
    logic [7:0] v;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    v = 8'($urandom);
    if (pick < 45) begin
      op = OP_PRESS;
      // most presses hit a mapped key, some hit enter or f1..f4, rest anything
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        while (KEYMAP[v] == 8'h00) v = 8'($urandom);
      end else if (pick < 80) begin
        v = ($urandom_range(0, 4) == 0) ? KEY_ENTER : KEY_F1 + 8'($urandom_range(0, 3));
      end
    end else if (pick < 65) begin
      op = OP_RELEASE;
      if ($urandom_range(0, 9) < 7) v = KEY_SHIFT + 8'($urandom_range(0, 2));
    end else if (pick < 95) begin
      op = OP_CMD;
      pick = $urandom_range(0, 99);
      if (pick < 30) grp = CMD_LED;
      else if (pick < 42) grp = CMD_LEDRD;
      else if (pick < 54) grp = CMD_SWRD;
      else if (pick < 62) grp = CMD_REPEAT;
      else if (pick < 67) grp = $urandom_range(0, 1) ? CMD_RPT1 : CMD_RPT0;
      else if (pick < 82) grp = CMD_ENABLE;
      else grp = CMD_RESET;
      v[7:5] = grp;
      // keep the keyboard enabled most of the time
      if (grp == CMD_ENABLE) v[0] = ($urandom_range(0, 9) < 7);
    end else begin
      op = OP_SPARE;
    end
    send_event(op, v, 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    burst_left = $urandom_range(1, 8);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: key map edges, shifted remaps, break codes
    send_event(OP_PRESS, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, 8'hff, 1'b1, 1'b1, 1'b1);
    send_event(OP_PRESS, 8'h41, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, KEY_ENTER, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, KEY_ENTER, 1'b1, 1'b0, 1'b0);
    send_event(OP_PRESS, KEY_F1, 1'b1, 1'b0, 1'b0);
    send_event(OP_PRESS, KEY_F4, 1'b1, 1'b0, 1'b0);
    send_event(OP_PRESS, KEY_F1 + 8'd1, 1'b0, 1'b1, 1'b1);
    send_event(OP_RELEASE, KEY_SHIFT, 1'b0, 1'b0, 1'b0);
    send_event(OP_RELEASE, KEY_CTRL, 1'b0, 1'b0, 1'b0);
    send_event(OP_RELEASE, KEY_GRAPH, 1'b0, 1'b0, 1'b0);
    // released key that is not a modifier, then the unused opcode
    send_event(OP_RELEASE, 8'h41, 1'b1, 1'b1, 1'b1);
    send_event(OP_SPARE, 8'hff, 1'b1, 1'b1, 1'b1);
    // leds, status reads, repeat and timing commands
    send_event(OP_CMD, {CMD_LED, 5'h01}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_LED, 5'h0f}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_LEDRD, 5'h00}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_SWRD, 5'h00}, 1'b1, 1'b1, 1'b1);
    send_event(OP_CMD, {CMD_SWRD, 5'h1f}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_REPEAT, 5'h00}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_RPT0, 5'h00}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_RPT1, 5'h1f}, 1'b0, 1'b0, 1'b0);
    // disabled keyboard ignores keys but still takes commands
    send_event(OP_CMD, {CMD_ENABLE, 5'h00}, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, 8'h41, 1'b0, 1'b0, 1'b0);
    send_event(OP_RELEASE, KEY_SHIFT, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_ENABLE, 5'h1f}, 1'b0, 1'b0, 1'b0);
    // reset with and without diagnostic byte, then check leds were cleared
    send_event(OP_CMD, {CMD_RESET, 5'h00}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_LED, 5'h0b}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_RESET, 5'h1f}, 1'b0, 1'b0, 1'b0);
    send_event(OP_CMD, {CMD_LEDRD, 5'h1f}, 1'b0, 1'b0, 1'b0);

    while (counted < EVENT_TARGET) send_random_event();
    push <= 1'b0;

    // drain, then give the block time to show any stray bytes
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d presses, %0d releases, %0d commands, %0d unused opcodes",
             sb.n_press, sb.n_release, sb.n_cmd, sb.n_spare);
    $display("%0d status bursts, %0d bytes checked, %0d mismatches",
             sb.n_status, sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[keyboard_controller_command_unit_core] OK");
    end else begin
      $display("[keyboard_controller_command_unit_core] ERROR");
    end
    $finish;
  end

endmodule
